// ----- sv/sct_pkg.sv -----
// sct_pkg: shared types and constants for the sine/cosine series evaluator.
// Used by sct_mulq, sct_term and sine_cosine_taylor. No dependencies.
package sct_pkg;

   localparam int ANGLE_W = 32;
   localparam int RES_W = 32;
   localparam int MAG_W = 63;
   localparam int Q_W = 64;
   localparam int FRAC = 58;
   localparam int DEF_SERIES_TERMS = 11;

   localparam logic [Q_W-1:0] ONE_Q58 = Q_W'(1) << FRAC;
   localparam logic [50:0] TWO_PI_Q48 = 51'h6487ED5110B46;
   localparam logic signed [Q_W-1:0] PI_Q48 = 64'sh3243F6A8885A3;
   localparam logic signed [Q_W-1:0] TWO_PI_S = 64'sh6487ED5110B46;
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

   // Operand set that travels down the series pipeline, sign and magnitude.
   typedef struct packed {
      logic             x_sign;
      logic [MAG_W-1:0] x_mag;
      logic [MAG_W-1:0] x2;
      logic             qs_sign;
      logic [MAG_W-1:0] qs_mag;
      logic             qc_sign;
      logic [MAG_W-1:0] qc_mag;
   } sct_state_type;

endpackage

// ----- sv/sct_mulq.sv -----
// sct_mulq: two-stage 63x63 unsigned multiplier built from four partial products of 32- and 31-bit slices.
// Returns the Q58 product rounded half up, or the product shifted right by 63.
// Depends on sct_pkg.
module sct_mulq (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     recip,
   input  logic [sct_pkg::MAG_W-1:0] a,
   input  logic [sct_pkg::MAG_W-1:0] b,
   output logic [sct_pkg::Q_W-1:0]   prod
);
   import sct_pkg::*;

   logic [63:0]  p00_ff;
   logic [62:0]  p01_ff;
   logic [62:0]  p10_ff;
   logic [61:0]  p11_ff;
   logic [Q_W-1:0] prod_ff;
   logic [Q_W-1:0] prod_in;
   logic [125:0] sum;

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff  <= 64'(a[31:0]) * 64'(b[31:0]);
         p01_ff  <= 63'(a[31:0]) * 63'(b[62:32]);
         p10_ff  <= 63'(a[62:32]) * 63'(b[31:0]);
         p11_ff  <= 62'(a[62:32]) * 62'(b[62:32]);
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      sum = 126'(p00_ff) + (126'(p01_ff) << 32) + (126'(p10_ff) << 32)
          + (126'(p11_ff) << 64);
      if (recip) begin
         prod_in = Q_W'(sum >> 63);
      end else begin
         prod_in = Q_W'(sum >> FRAC) + Q_W'(sum[FRAC-1]);
      end
   end

   assign prod = prod_ff;

endmodule

// ----- sv/sct_term.sv -----
// sct_term: one nested series step for sine and cosine, six register stages.
// q = 1 - (x^2*q)/d with d divided out by reciprocal multiply and one correction.
// Depends on sct_pkg and sct_mulq.
module sct_term #(
   parameter int N = 1
) (
   input  logic                       clock,
   input  logic                       en,
   input  sct_pkg::sct_state_type     state_in,
   output sct_pkg::sct_state_type     state_out
);
   import sct_pkg::*;

   localparam logic [Q_W-1:0] DS = Q_W'((2 * N) * (2 * N + 1));
   localparam logic [Q_W-1:0] DC = Q_W'((2 * N - 1) * (2 * N));
   localparam logic [Q_W-1:0] RECIP_S = (Q_W'(1) << 63) / DS;
   localparam logic [Q_W-1:0] RECIP_C = (Q_W'(1) << 63) / DC;

   sct_state_type  pipe_ff [5];
   sct_state_type  out_ff;
   sct_state_type  out_in;
   logic [Q_W-1:0] ms;
   logic [Q_W-1:0] mc;
   logic [Q_W-1:0] es;
   logic [Q_W-1:0] ec;
   logic [Q_W-1:0] ms_d_ff [2];
   logic [Q_W-1:0] mc_d_ff [2];
   logic [Q_W-1:0] qts_ff;
   logic [Q_W-1:0] qtc_ff;
   logic [Q_W-1:0] qts_in;
   logic [Q_W-1:0] qtc_in;
   logic [Q_W-1:0] rem_s;
   logic [Q_W-1:0] rem_c;
   logic [Q_W-1:0] sum_s;
   logic [Q_W-1:0] sum_c;

   sct_mulq u_mul_s (
      .clock(clock), .en(en), .recip(1'b0),
      .a(state_in.x2), .b(state_in.qs_mag), .prod(ms)
   );
   sct_mulq u_mul_c (
      .clock(clock), .en(en), .recip(1'b0),
      .a(state_in.x2), .b(state_in.qc_mag), .prod(mc)
   );
   sct_mulq u_div_s (
      .clock(clock), .en(en), .recip(1'b1),
      .a(MAG_W'(ms)), .b(MAG_W'(RECIP_S)), .prod(es)
   );
   sct_mulq u_div_c (
      .clock(clock), .en(en), .recip(1'b1),
      .a(MAG_W'(mc)), .b(MAG_W'(RECIP_C)), .prod(ec)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= state_in;
         for (int i = 1; i < 5; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
         ms_d_ff[0] <= ms;
         ms_d_ff[1] <= ms_d_ff[0];
         mc_d_ff[0] <= mc;
         mc_d_ff[1] <= mc_d_ff[0];
         qts_ff     <= qts_in;
         qtc_ff     <= qtc_in;
         out_ff     <= out_in;
      end
   end

   // quotient estimate is exact or one low
   always_comb begin
      rem_s  = ms_d_ff[1] - Q_W'(es * DS);
      rem_c  = mc_d_ff[1] - Q_W'(ec * DC);
      qts_in = (rem_s >= DS) ? es + Q_W'(1) : es;
      qtc_in = (rem_c >= DC) ? ec + Q_W'(1) : ec;
   end

   always_comb begin
      out_in = pipe_ff[4];
      sum_s  = ONE_Q58 + qts_ff;
      sum_c  = ONE_Q58 + qtc_ff;
      if (pipe_ff[4].qs_sign) begin
         out_in.qs_sign = 1'b0;
         out_in.qs_mag  = MAG_W'(sum_s);
      end else if (qts_ff > ONE_Q58) begin
         out_in.qs_sign = 1'b1;
         out_in.qs_mag  = MAG_W'(qts_ff - ONE_Q58);
      end else begin
         out_in.qs_sign = 1'b0;
         out_in.qs_mag  = MAG_W'(ONE_Q58 - qts_ff);
      end
      if (pipe_ff[4].qc_sign) begin
         out_in.qc_sign = 1'b0;
         out_in.qc_mag  = MAG_W'(sum_c);
      end else if (qtc_ff > ONE_Q58) begin
         out_in.qc_sign = 1'b1;
         out_in.qc_mag  = MAG_W'(qtc_ff - ONE_Q58);
      end else begin
         out_in.qc_sign = 1'b0;
         out_in.qc_mag  = MAG_W'(ONE_Q58 - qtc_ff);
      end
   end

   assign state_out = out_ff;

endmodule

// ----- sv/sine_cosine_taylor.sv -----
// sine_cosine_taylor: pipelined sine and cosine of a Q16.16 angle, Q2.30 results.
// Range reduction, x^2, one sct_term per series step, final product and rounding.
// Depends on sct_pkg, sct_mulq and sct_term.
//
//   channel  handshake          payload
//   req      req_valid/ready    req_angle  (Q16.16 signed)
//   rsp      rsp_valid/ready    rsp_sine, rsp_cosine (Q2.30 signed)
//
// One request per cycle while the pipeline is not held. Register stages: 7 for reduction,
// 2 for x^2, 6 per series step, 3 for the output.
// The whole pipeline holds while a result waits and rsp_ready is low.
// Reset clears the valid bits only.
module sine_cosine_taylor #(
   parameter int SERIES_TERMS = sct_pkg::DEF_SERIES_TERMS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [sct_pkg::ANGLE_W-1:0] req_angle,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [sct_pkg::RES_W-1:0]   rsp_sine,
   output logic signed [sct_pkg::RES_W-1:0]   rsp_cosine
);
   import sct_pkg::*;

   localparam int LAT = 12 + 6 * (SERIES_TERMS - 1);

   logic             en;
   logic [LAT-1:0]   valid_ff;

   logic             neg_ff [6];
   logic [31:0]      xa_ff [4];
   logic [61:0]      prodk_ff;
   logic [12:0]      k_ff;
   logic [Q_W-1:0]   kp_ff;
   logic signed [Q_W-1:0] r_ff;
   logic signed [Q_W-1:0] rc_ff;
   logic signed [Q_W-1:0] rc_in;
   logic [Q_W-1:0]   rabs;
   logic             xs_ff;
   logic [MAG_W-1:0] xm_ff;
   logic             xs_d_ff [2];
   logic [MAG_W-1:0] xm_d_ff [2];
   logic [Q_W-1:0]   x2;

   sct_state_type    chain [SERIES_TERMS];
   sct_state_type    fin_d_ff [2];
   logic [Q_W-1:0]   sine_mag;
   logic [RES_W-1:0] sine_ff;
   logic [RES_W-1:0] cosine_ff;

   function automatic logic [RES_W-1:0] to_q30(input logic sgn, input logic [Q_W-1:0] mag);
      logic [Q_W-1:0] m;
      logic [Q_W-1:0] r;
      m = (mag + (Q_W'(1) << (FRAC - 31))) >> (FRAC - 30);
      if (!sgn && m > Q_W'(32'h7FFF_FFFF)) m = Q_W'(32'h7FFF_FFFF);
      if (sgn && m > Q_W'(32'h8000_0000)) m = Q_W'(32'h8000_0000);
      r = sgn ? Q_W'(0) - m : m;
      return r[RES_W-1:0];
   endfunction

   assign en        = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   // range reduction
   always_comb begin
      if (r_ff >= PI_Q48) begin
         rc_in = r_ff - TWO_PI_S;
      end else if (r_ff < -PI_Q48) begin
         rc_in = r_ff + TWO_PI_S;
      end else begin
         rc_in = r_ff;
      end
      rabs = rc_ff[Q_W-1] ? Q_W'(0) - Q_W'(rc_ff) : Q_W'(rc_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= req_angle[ANGLE_W-1];
         xa_ff[0]  <= req_angle[ANGLE_W-1] ? 32'(0) - 32'(req_angle) : 32'(req_angle);
         for (int i = 1; i < 6; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
         for (int i = 1; i < 4; i++) begin
            xa_ff[i] <= xa_ff[i-1];
         end
         prodk_ff <= 62'(xa_ff[0]) * 62'(INV_TWO_PI_Q32);
         k_ff     <= 13'((prodk_ff + (62'(1) << 47)) >> 48);
         kp_ff    <= Q_W'(k_ff) * Q_W'(TWO_PI_Q48);
         r_ff     <= $signed({xa_ff[3], 32'h0} - kp_ff);
         rc_ff    <= rc_in;
         xs_ff    <= neg_ff[5] ^ rc_ff[Q_W-1];
         xm_ff    <= MAG_W'(rabs << 10);
         xs_d_ff[0] <= xs_ff;
         xs_d_ff[1] <= xs_d_ff[0];
         xm_d_ff[0] <= xm_ff;
         xm_d_ff[1] <= xm_d_ff[0];
      end
   end

   sct_mulq u_sq (
      .clock(clock), .en(en), .recip(1'b0), .a(xm_ff), .b(xm_ff), .prod(x2)
   );

   always_comb begin
      chain[0].x_sign  = xs_d_ff[1];
      chain[0].x_mag   = xm_d_ff[1];
      chain[0].x2      = MAG_W'(x2);
      chain[0].qs_sign = 1'b0;
      chain[0].qs_mag  = MAG_W'(ONE_Q58);
      chain[0].qc_sign = 1'b0;
      chain[0].qc_mag  = MAG_W'(ONE_Q58);
   end

   for (genvar i = 0; i < SERIES_TERMS - 1; i++) begin : g_term
      sct_term #(
         .N(SERIES_TERMS - 1 - i)
      ) u_term (
         .clock(clock), .en(en), .state_in(chain[i]), .state_out(chain[i+1])
      );
   end

   sct_mulq u_sine (
      .clock(clock), .en(en), .recip(1'b0),
      .a(chain[SERIES_TERMS-1].x_mag), .b(chain[SERIES_TERMS-1].qs_mag), .prod(sine_mag)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         fin_d_ff[0] <= chain[SERIES_TERMS-1];
         fin_d_ff[1] <= fin_d_ff[0];
         sine_ff     <= to_q30(fin_d_ff[1].x_sign ^ fin_d_ff[1].qs_sign, sine_mag);
         cosine_ff   <= to_q30(fin_d_ff[1].qc_sign, Q_W'(fin_d_ff[1].qc_mag));
      end
   end

   assign rsp_valid  = valid_ff[LAT-1];
   assign rsp_sine   = $signed(sine_ff);
   assign rsp_cosine = $signed(cosine_ff);

endmodule

// ----- dv/sine_cosine_taylor_test.sv -----
// Testbench for sine_cosine_taylor: directed and random angles with idle and stall phases.
// Built-in predictor of the reduction and series; results checked in order.
// Depends on sct_pkg and the sine_cosine_taylor RTL.
module sine_cosine_taylor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sct_pkg::*;

   typedef struct {
      logic [31:0] sine;
      logic [31:0] cosine;
   } trig_pair_type;

   class trig_scoreboard;
      trig_pair_type pending[$];
      int errors = 0;

      function automatic longint unsigned magnitude(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      function automatic longint wrap_clamp(logic [63:0] u);
         logic [63:0] m;
         if (u[63]) begin
            m = -u;
            if (m > (64'd1 << 62)) m = 64'd1 << 62;
            return -longint'(m);
         end
         if (u > (64'd1 << 62)) u = 64'd1 << 62;
         return longint'(u);
      endfunction

      function automatic longint mul_q58(longint a, longint b);
         logic neg;
         logic [127:0] p;
         logic [63:0] m;
         neg = (a < 0) != (b < 0);
         p = 128'(magnitude(a)) * 128'(magnitude(b));
         m = p[121:58];
         m = m + 64'(p[57]);
         if (p[127:121] != 0 || m > (64'd1 << 62)) m = 64'd1 << 62;
         return neg ? -longint'(m) : longint'(m);
      endfunction

      function automatic logic [31:0] round_q30(longint v);
         logic neg;
         logic [63:0] m;
         neg = v < 0;
         m = magnitude(v);
         m = (m + (64'd1 << 27)) >> 28;
         if (!neg && m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
         if (neg && m > 64'h8000_0000) m = 64'h8000_0000;
         return neg ? 32'(-m) : 32'(m);
      endfunction

      function automatic trig_pair_type evaluate(logic [31:0] angle);
         trig_pair_type res;
         logic neg;
         logic [63:0] xa, k;
         longint r, x, x2, qs, qc, one;
         neg = angle[31];
         xa = neg ? (64'h1_0000_0000 - 64'(angle)) : 64'(angle);
         k = (xa * 64'd683565276 + (64'd1 << 47)) >> 48;
         r = wrap_clamp((xa << 32) - k * 64'(TWO_PI_S));
         if (r >= PI_Q48) r = r - TWO_PI_S;
         else if (r < -PI_Q48) r = r + TWO_PI_S;
         if (neg) r = -r;
         one = longint'(1) << FRAC;
         x = r * 1024;
         x2 = mul_q58(x, x);
         qs = one;
         qc = one;
         for (int n = DEF_SERIES_TERMS - 1; n >= 1; n--) begin
            qs = one - mul_q58(x2, qs) / longint'((2 * n) * (2 * n + 1));
            qc = one - mul_q58(x2, qc) / longint'((2 * n - 1) * (2 * n));
         end
         res.sine = round_q30(mul_q58(x, qs));
         res.cosine = round_q30(qc);
         return res;
      endfunction

      function void note_request(logic [31:0] angle);
         pending.push_back(evaluate(angle));
      endfunction

      function void check_result(logic [31:0] sine, logic [31:0] cosine);
         trig_pair_type exp_pair;
         if (pending.size() == 0) begin
            $error("unexpected result sine=%h cosine=%h", sine, cosine);
            errors++;
            return;
         end
         exp_pair = pending.pop_front();
         if (sine !== exp_pair.sine) begin
            $error("sine: expected %h, actual %h", exp_pair.sine, sine);
            errors++;
         end
         if (cosine !== exp_pair.cosine) begin
            $error("cosine: expected %h, actual %h", exp_pair.cosine, cosine);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [31:0] req_angle = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_sine, rsp_cosine;

   int idle_pct = 0;
   int stall_pct = 0;
   longint cycles = 0;
   trig_scoreboard sb = new();

   sine_cosine_taylor dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_angle);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_sine, rsp_cosine);
      end
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   task automatic send_angle(logic [31:0] a);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_angle <= a;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random(int count);
      logic [31:0] a;
      repeat (count) begin
         case ($urandom_range(3))
            0: a = $urandom();
            1: a = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: a = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            default: a = 32'($signed($urandom_range(0, 823550)) - 411775);
         endcase
         send_angle(a);
      end
   endtask

   initial begin
      logic [31:0] directed[$];
      directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'd102944,
                   32'd205887, 32'd205888, -32'sd205887, -32'sd205888,
                   32'd411775, -32'sd411775, 32'd617661, 32'd617662,
                   -32'sd617661, -32'sd617662, 32'd1029436, 32'h4000_0000,
                   32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
      repeat (6) @(posedge clock);
      reset <= 0;
      foreach (directed[i]) send_angle(directed[i]);
      send_random(125);
      idle_pct = 67;
      send_random(125);
      idle_pct = 0;
      stall_pct = 67;
      send_random(125);
      idle_pct = 35;
      stall_pct = 35;
      send_random(125);
      req_valid <= 0;
      stall_pct = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
